FILE: hdl/bd3_pkg.sv
package bd3_pkg;

  // Field widths fixed by the interface.
  localparam int PIX_W      = 8;
  localparam int COL_OUT_W  = 10;
  localparam int ROW_W      = 12;
  localparam int IMG_W_W    = 11;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 2;

  // Default line length of the line stores.
  localparam int MAX_WIDTH_DEF = 1024;

  // Width and height after reset.
  localparam int RESET_WIDTH  = 1024;
  localparam int RESET_HEIGHT = 1024;

  // Smallest frame dimension that still has an interior.
  localparam int MIN_DIM = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  // Value of a set (white) pixel.
  localparam logic [PIX_W-1:0] PIX_SET = 8'hFF;

  // Two rows of one column as held in the line stores.
  typedef struct packed {
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] lower;
  } line_pair_t;

endpackage

FILE: hdl/bd3_pixel_in_if.sv
interface bd3_pixel_in_if;
  logic                      valid;
  logic                      ready;
  logic [bd3_pkg::PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

FILE: hdl/bd3_pixel_out_if.sv
interface bd3_pixel_out_if;
  logic                          valid;
  logic                          ready;
  logic [bd3_pkg::PIX_W-1:0]     pixel_out;
  logic [bd3_pkg::COL_OUT_W-1:0] out_column;
  logic [bd3_pkg::ROW_W-1:0]     out_row;
  logic                          frame_last;

  modport source (output valid, output pixel_out, output out_column, output out_row,
                  output frame_last, input ready);
  modport sink   (input valid, input pixel_out, input out_column, input out_row,
                  input frame_last, output ready);
endinterface

FILE: hdl/binary_dilation_3x3_unit.sv
// 3x3 binary dilation over a raster pixel stream. One pixel item is taken per
// clock while the output is not stalled; the result for interior pixel (x-1,y-1)
// is in the output register in the cycle after the pixel at (x,y) is accepted,
// and border pixels produce no item. The rate is set by the line-store memory: it
// has one write and one registered read port, and the read for the next column
// is issued early from the next-column value, so each pixel needs exactly one read
// and one write. The line stores are not cleared after reset; the first two
// rows of a frame fill them before any result depends on them. A write to
// either configuration register restarts the frame at column 0, row 0, and
// must only be made while the block is idle.
module binary_dilation_3x3_unit #(
  parameter int MAX_WIDTH = bd3_pkg::MAX_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [bd3_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bd3_pkg::CFG_DATA_W-1:0]   cfg_data,
  bd3_pixel_in_if.sink                     pix_in,
  bd3_pixel_out_if.source                  pix_out
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  // Wide enough for both the whole width register and MAX_WIDTH itself.
  localparam int WIDE_W = (CW + 2 > bd3_pkg::IMG_W_W) ? CW + 2 : bd3_pkg::IMG_W_W;
  localparam int RESET_W_EFF =
    (MAX_WIDTH < bd3_pkg::RESET_WIDTH) ? MAX_WIDTH : bd3_pkg::RESET_WIDTH;
  localparam logic [CW-1:0] COL_LAST_RST = CW'(RESET_W_EFF - 1);
  localparam logic [bd3_pkg::ROW_W-1:0] ROW_LAST_RST =
    bd3_pkg::ROW_W'(bd3_pkg::RESET_HEIGHT - 1);

  // Last column and last row of the frame, already saturated.
  logic [CW-1:0]               col_last;
  logic [bd3_pkg::ROW_W-1:0]   row_last;
  logic [CW-1:0]               col_last_cfg;
  logic [bd3_pkg::ROW_W-1:0]   row_last_cfg;
  logic [WIDE_W-1:0]           width_wide;
  logic [bd3_pkg::ROW_W-1:0]   height_cfg;

  // Position of the next pixel to arrive.
  logic [CW-1:0]               col;
  logic [CW-1:0]               col_next;
  logic [bd3_pkg::ROW_W-1:0]   row;
  logic [bd3_pkg::ROW_W-1:0]   row_next;

  logic                        accept;
  logic                        emit;
  logic                        cfg_restart;
  logic [CW-1:0]               col_m1;
  logic [bd3_pkg::ROW_W-1:0]   row_m1;

  bd3_pkg::line_pair_t         column;
  bd3_pkg::line_pair_t         store_wr;
  logic [bd3_pkg::PIX_W-1:0]   result;

  // Output register.
  logic                          out_valid;
  logic [bd3_pkg::PIX_W-1:0]     out_pixel;
  logic [bd3_pkg::COL_OUT_W-1:0] out_col;
  logic [bd3_pkg::ROW_W-1:0]     out_row;
  logic                          out_last;

  // A new item is taken whenever the output register is empty or being drained.
  assign pix_in.ready = !out_valid || pix_out.ready;
  assign accept       = pix_in.valid && pix_in.ready;
  assign emit         = (col >= CW'(2)) && (row >= bd3_pkg::ROW_W'(2));

  // Saturate the configured width to MIN_DIM..MAX_WIDTH and height to at least
  // MIN_DIM, kept as last index so the counters compare directly.
  assign width_wide = WIDE_W'(cfg_data[bd3_pkg::IMG_W_W-1:0]);
  assign height_cfg = cfg_data[bd3_pkg::ROW_W-1:0];

  always_comb begin
    if (width_wide < WIDE_W'(bd3_pkg::MIN_DIM)) begin
      col_last_cfg = CW'(bd3_pkg::MIN_DIM - 1);
    end else if (width_wide > WIDE_W'(MAX_WIDTH)) begin
      col_last_cfg = CW'(MAX_WIDTH - 1);
    end else begin
      col_last_cfg = CW'(width_wide - WIDE_W'(1));
    end
    if (height_cfg < bd3_pkg::ROW_W'(bd3_pkg::MIN_DIM)) begin
      row_last_cfg = bd3_pkg::ROW_W'(bd3_pkg::MIN_DIM - 1);
    end else begin
      row_last_cfg = height_cfg - bd3_pkg::ROW_W'(1);
    end
  end

  always_comb begin
    cfg_restart = 1'b0;
    if (cfg_write) begin
      case (cfg_index)
        bd3_pkg::REG_IMAGE_WIDTH:  cfg_restart = 1'b1;
        bd3_pkg::REG_IMAGE_HEIGHT: cfg_restart = 1'b1;
        default:                   cfg_restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_last <= COL_LAST_RST;
      row_last <= ROW_LAST_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        bd3_pkg::REG_IMAGE_WIDTH:  col_last <= col_last_cfg;
        bd3_pkg::REG_IMAGE_HEIGHT: row_last <= row_last_cfg;
        default: begin
        end
      endcase
    end
  end

  // Raster position. The next column also drives the line-store read, so the
  // two rows above the next pixel are waiting in the read register on arrival.
  always_comb begin
    col_next = col;
    row_next = row;
    if (cfg_restart) begin
      col_next = '0;
      row_next = '0;
    end else if (accept) begin
      if (col == col_last) begin
        col_next = '0;
        row_next = (row == row_last) ? '0 : row + bd3_pkg::ROW_W'(1);
      end else begin
        col_next = col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
    end
  end

  // The middle row moves up and the new pixel becomes the middle row.
  assign store_wr.upper = column.lower;
  assign store_wr.lower = pix_in.pixel_in;

  bd3_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (col),
    .wr_data (store_wr),
    .rd_addr (col_next),
    .rd_data (column)
  );

  bd3_window u_window (
    .clk    (clk),
    .rst    (rst),
    .shift  (accept),
    .pix    (pix_in.pixel_in),
    .column (column),
    .result (result)
  );

  assign col_m1 = col - CW'(1);
  assign row_m1 = row - bd3_pkg::ROW_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && emit) begin
      out_valid <= 1'b1;
    end else if (pix_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_pixel <= result;
      out_col   <= bd3_pkg::COL_OUT_W'(col_m1);
      out_row   <= row_m1;
      out_last  <= (col == col_last) && (row == row_last);
    end
  end

  assign pix_out.valid      = out_valid;
  assign pix_out.pixel_out  = out_pixel;
  assign pix_out.out_column = out_col;
  assign pix_out.out_row    = out_row;
  assign pix_out.frame_last = out_last;

endmodule

FILE: hdl/bd3_line_buf.sv
module bd3_line_buf #(
  parameter int MAX_WIDTH = bd3_pkg::MAX_WIDTH_DEF,
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  bd3_pkg::line_pair_t wr_data,
  input  logic [AW-1:0]       rd_addr,
  output bd3_pkg::line_pair_t rd_data
);

  // Both line stores share one address, so they are kept as one wide memory.
  bd3_pkg::line_pair_t mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hdl/bd3_window.sv
module bd3_window (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      shift,
  input  logic [bd3_pkg::PIX_W-1:0] pix,
  input  bd3_pkg::line_pair_t       column,
  output logic [bd3_pkg::PIX_W-1:0] result
);

  // Entries 0..2 hold column x-2 (top, middle, bottom), 3..5 hold column x-1.
  logic [bd3_pkg::PIX_W-1:0] win [6];
  logic                      any_set;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (shift) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= column.upper;
      win[4] <= column.lower;
      win[5] <= pix;
    end
  end

  // The centre is win[4]; the eight neighbours are the rest of the window.
  always_comb begin
    any_set = (win[0] == bd3_pkg::PIX_SET) || (win[1] == bd3_pkg::PIX_SET) ||
              (win[2] == bd3_pkg::PIX_SET) || (win[3] == bd3_pkg::PIX_SET) ||
              (win[5] == bd3_pkg::PIX_SET) || (column.upper == bd3_pkg::PIX_SET) ||
              (column.lower == bd3_pkg::PIX_SET) || (pix == bd3_pkg::PIX_SET);
    if (win[4] != '0) begin
      result = win[4];
    end else if (any_set) begin
      result = bd3_pkg::PIX_SET;
    end else begin
      result = '0;
    end
  end

endmodule

FILE: hdl/bd3_checker.sv
module bd3_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bd3_pkg::PIX_W-1:0]     pixel_out,
  input logic [bd3_pkg::COL_OUT_W-1:0] out_column,
  input logic [bd3_pkg::ROW_W-1:0]     out_row
);

  // A stalled result keeps its value until taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_out) &&
      $stable(out_column) && $stable(out_row))
    else $error("stalled result changed");

  // With the output register empty the block must be ready to take an item.
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // A new result only follows an accepted item.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !$past(out_valid) |-> $past(in_valid && in_ready))
    else $error("result appeared without an accepted item");

  // Pixels in column 0 or row 0 are never reported.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_column != '0) && (out_row != '0))
    else $error("border pixel reported");

endmodule

bind binary_dilation_3x3_unit bd3_checker u_bd3_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (pix_in.valid),
  .in_ready   (pix_in.ready),
  .out_valid  (pix_out.valid),
  .out_ready  (pix_out.ready),
  .pixel_out  (pix_out.pixel_out),
  .out_column (pix_out.out_column),
  .out_row    (pix_out.out_row)
);
